/* src/vrt_pkg.sv */
// Package: shared constants and types for the rotated-volume sampler.
`default_nettype none
package vrt_pkg;
   localparam int MAX_SIDE_DEF  = 32;
   localparam int VOXEL_BITS_DEF = 16;
   localparam int COEF_FRAC_DEF = 16;
   localparam int COORD_BITS    = 5;
   localparam int SIZE_BITS     = 6;
   localparam int CSR_DATA_BITS = 54;
   localparam int CSR_IDX_BITS  = 3;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_SIZE_X = 3'd0,
      CSR_SIZE_Y = 3'd1,
      CSR_SIZE_Z = 3'd2,
      CSR_COEF_X = 3'd3,
      CSR_COEF_Y = 3'd4,
      CSR_COEF_Z = 3'd5
   } csr_index_type;

   localparam logic REQ_STORE   = 1'b0;
   localparam logic REQ_COMPUTE = 1'b1;
endpackage
`default_nettype wire

/* src/vrt_if.sv */
// Interfaces: valid/ready item channels for requests and results.
`default_nettype none
interface vrt_req_if #(parameter int VOXEL_BITS = 16);
   logic                   valid;
   logic                   ready;
   logic                   req_type;
   logic [4:0]             coord_x;
   logic [4:0]             coord_y;
   logic [4:0]             coord_z;
   logic signed [VOXEL_BITS-1:0] voxel_value;
   modport source (output valid, req_type, coord_x, coord_y, coord_z, voxel_value,
                   input ready);
   modport sink   (input valid, req_type, coord_x, coord_y, coord_z, voxel_value,
                   output ready);
endinterface

interface vrt_rsp_if #(parameter int VOXEL_BITS = 16);
   logic                   valid;
   logic                   ready;
   logic signed [VOXEL_BITS-1:0] out_value;
   logic                   inside_res;
   modport source (output valid, out_value, inside_res, input ready);
   modport sink   (input valid, out_value, inside_res, output ready);
endinterface
`default_nettype wire

/* src/vrt_ram.sv */
// Generic single-port RAM with registered read data.
`default_nettype none
module vrt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

/* src/volume_rotate_trilinear.sv */
// Rotated-volume sampler (top level): voxel store plus trilinear resampling.
//
// Channels: req (sink) carries store and compute items; rsp (source) carries
// one result item per compute item and nothing for store items. csr is a
// plain write port: csr_wr_en, csr_index (register order x,y,z size, then
// x,y,z coefficient triples) and csr_data.
// A store item is accepted, then written to memory in S_WRITE.
// A compute item: source-point math (one axis per cycle, three 18x8
// multiply-adds per axis, registered), then 8 neighbour reads on the single
// volume memory port, one per cycle, each folded into the interpolation as
// it returns, then y blend, z blend and result load. The next item is
// accepted only after the result load; no new item is taken while one is
// in progress. The memory port serialises the 8 reads.
// Points outside the volume skip the reads and blends and go to the result load.
// Reset clears control state and restores sizes 32 and the identity matrix;
// the volume memory is not cleared and holds garbage until written.
// A finished result waits in the rsp register while new items are taken; a
// compute item stalls at its result load until that register is free.
`default_nettype none
module volume_rotate_trilinear
   import vrt_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   vrt_req_if.sink                       req,
   vrt_rsp_if.source                     rsp,
   input  wire logic                     csr_wr_en,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_data
);
   localparam int MAX_SIDE       = MAX_SIDE_DEF;
   localparam int VOXEL_BITS     = VOXEL_BITS_DEF;
   localparam int COEF_FRAC_BITS = COEF_FRAC_DEF;
   localparam int CB    = COEF_FRAC_BITS + 2;
   localparam int WB    = (COEF_FRAC_BITS < 16) ? COEF_FRAC_BITS : 16;
   localparam int SB    = $clog2(MAX_SIDE);
   localparam int DEPTH = MAX_SIDE * MAX_SIDE * MAX_SIDE;
   localparam int AB    = 3 * SB;
   // source coordinate: sign + integer (SB+7 bits; SB+3 covers worst matrix sums) + frac
   localparam int RB    = CB + SB + 6;
   localparam int AX    = VOXEL_BITS + WB + 2;     // x stage
   localparam int AY    = AX + WB + 1;             // y stage before shift
   localparam int AZ    = VOXEL_BITS + 2 * WB + 3; // z stage

   typedef enum logic [2:0] {
      S_IDLE, S_WRITE, S_MAP, S_READ, S_BLEND, S_ZBLEND, S_DONE
   } state_type;

   // configuration
   logic [SIZE_BITS-1:0] size_ff [3];
   logic [3*CB-1:0]      coef_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            size_ff[a] <= SIZE_BITS'(32);
            coef_ff[a] <= (3*CB)'(1) << (a * CB + COEF_FRAC_BITS);
         end
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SIZE_X: size_ff[0] <= csr_data[SIZE_BITS-1:0];
            CSR_SIZE_Y: size_ff[1] <= csr_data[SIZE_BITS-1:0];
            CSR_SIZE_Z: size_ff[2] <= csr_data[SIZE_BITS-1:0];
            CSR_COEF_X: coef_ff[0] <= csr_data[3*CB-1:0];
            CSR_COEF_Y: coef_ff[1] <= csr_data[3*CB-1:0];
            CSR_COEF_Z: coef_ff[2] <= csr_data[3*CB-1:0];
            default: ;
         endcase
      end
   end

   // effective sizes, clamped to 2..MAX_SIDE
   logic [SB:0] eff [3];
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         if (size_ff[a] < SIZE_BITS'(2)) eff[a] = (SB+1)'(2);
         else if (32'(size_ff[a]) > MAX_SIDE) eff[a] = (SB+1)'(MAX_SIDE);
         else eff[a] = (SB+1)'(size_ff[a]);
      end
   end

   // item registers
   state_type              state_ff;
   logic [1:0]             axis_ff;
   logic [2:0]             nb_ff;
   logic [SB:0]            crd_ff [3];
   logic signed [VOXEL_BITS-1:0] wval_ff;
   logic [SB-1:0]          base_ff [3];
   logic [SB-1:0]          nxt_ff [3];
   logic [WB-1:0]          w_ff [3];
   logic                   outside_ff;
   logic                   rd_pend_ff;
   logic [2:0]             rd_nb_ff;
   logic signed [AX-1:0]   xacc_ff;
   logic signed [AY-1:0]   a_ff [4];
   logic signed [AY-1:0]   b_ff [2];
   logic signed [AZ-1:0]   z_ff;
   logic                   rsp_valid_ff;
   logic signed [VOXEL_BITS-1:0] rsp_val_ff;
   logic                   rsp_in_ff;
   logic                   sum_ok;
   logic                   rsp_load;

   // memory port
   logic               mem_we;
   logic [AB-1:0]      mem_addr;
   logic [VOXEL_BITS-1:0] mem_rd;

   vrt_ram #(.WIDTH(VOXEL_BITS), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .addr    (mem_addr),
      .wr_data (wval_ff),
      .rd_data (mem_rd)
   );

   // neighbour address: bit0 selects x, bit1 y, bit2 z
   logic [SB-1:0] nx, ny, nz;
   always_comb begin
      nx = nb_ff[0] ? nxt_ff[0] : base_ff[0];
      ny = nb_ff[1] ? nxt_ff[1] : base_ff[1];
      nz = nb_ff[2] ? nxt_ff[2] : base_ff[2];
      if (state_ff == S_WRITE)
         mem_addr = {crd_ff[2][SB-1:0], crd_ff[1][SB-1:0], crd_ff[0][SB-1:0]};
      else
         mem_addr = {nz, ny, nx};
      mem_we = (state_ff == S_WRITE) && sum_ok;
   end
   assign sum_ok = (crd_ff[0] < eff[0]) && (crd_ff[1] < eff[1]) && (crd_ff[2] < eff[2]);

   // source point for one axis: pivot*2^F + sum of coef*(coord-pivot)
   logic signed [CB-1:0]   cterm [3];
   logic signed [SB+2:0]   dlt [3];
   logic signed [RB-1:0]   rsrc;
   logic signed [RB-1:0]   rlim;
   logic [SB:0]            piv_a, lim_a;
   always_comb begin
      lim_a = eff[axis_ff];
      piv_a = lim_a >> 1;
      for (int t = 0; t < 3; t++) begin
         cterm[t] = coef_ff[axis_ff][t*CB +: CB];
         dlt[t]   = $signed({2'b00, crd_ff[t]}) - $signed({2'b00, eff[t] >> 1});
      end
      rsrc = $signed(RB'({piv_a, COEF_FRAC_BITS'(0)}));
      for (int t = 0; t < 3; t++)
         rsrc = rsrc + RB'(cterm[t]) * RB'(dlt[t]);
      rlim = $signed(RB'({lim_a - (SB+1)'(1), COEF_FRAC_BITS'(0)}));
   end

   // x-stage weights for the returning voxel, plus the y and z lerps
   logic signed [VOXEL_BITS-1:0] vrd;
   logic signed [WB+1:0]  wx, wxc;
   logic signed [AY+WB+1:0] ylerp0, ylerp1;
   logic signed [AZ+WB:0]  zlerp;
   always_comb begin
      vrd  = $signed(mem_rd);
      wx   = $signed({2'b00, w_ff[0]});
      wxc  = $signed((WB+2)'(1) << WB) - wx;
      ylerp0 = (AY+WB+2)'(a_ff[0]) * $signed({2'b00, (WB+1)'((1 << WB)) - (WB+1)'(w_ff[1])})
             + (AY+WB+2)'(a_ff[1]) * $signed({2'b00, w_ff[1]});
      ylerp1 = (AY+WB+2)'(a_ff[2]) * $signed({2'b00, (WB+1)'((1 << WB)) - (WB+1)'(w_ff[1])})
             + (AY+WB+2)'(a_ff[3]) * $signed({2'b00, w_ff[1]});
      zlerp  = (AZ+WB+1)'(b_ff[0]) * $signed({2'b00, (WB+1)'((1 << WB)) - (WB+1)'(w_ff[2])})
             + (AZ+WB+1)'(b_ff[1]) * $signed({2'b00, w_ff[2]});
   end

   // magnitude truncation of z result
   logic [AZ+WB:0] zmag;
   logic signed [AZ+WB:0] zres;
   always_comb begin
      zmag = z_ff[AZ-1] ? (AZ+WB+1)'(-z_ff) : (AZ+WB+1)'(z_ff);
      zmag = zmag >> (2 * WB);
      zres = z_ff[AZ-1] ? -$signed(zmag) : $signed(zmag);
   end

   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp.ready);
   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.out_value = rsp_val_ff;
   assign rsp.inside_res = rsp_in_ff;

   // result register: loaded when free or being taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
         rsp_val_ff   <= outside_ff ? '0 : VOXEL_BITS'(zres);
         rsp_in_ff    <= !outside_ff;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // sequencer: accept, store write, map, read-and-fold, blend, result load
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_pend_ff   <= 1'b0;
         axis_ff      <= 2'd0;
         nb_ff        <= 3'd0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req.valid && req.ready) begin
                  crd_ff[0] <= (SB+1)'(req.coord_x);
                  crd_ff[1] <= (SB+1)'(req.coord_y);
                  crd_ff[2] <= (SB+1)'(req.coord_z);
                  wval_ff   <= req.voxel_value;
                  axis_ff   <= 2'd0;
                  outside_ff <= 1'b0;
                  state_ff  <= (req.req_type == REQ_STORE) ? S_WRITE : S_MAP;
               end
            end
            S_WRITE: state_ff <= S_IDLE;
            S_MAP: begin
               if (rsrc < 0 || rsrc > rlim) outside_ff <= 1'b1;
               base_ff[axis_ff] <= SB'(rsrc >>> COEF_FRAC_BITS);
               nxt_ff[axis_ff]  <= ((SB+1)'(rsrc >>> COEF_FRAC_BITS) + (SB+1)'(1) < lim_a)
                                 ? SB'((rsrc >>> COEF_FRAC_BITS) + 1)
                                 : SB'(lim_a - (SB+1)'(1));
               w_ff[axis_ff] <= WB'(rsrc[COEF_FRAC_BITS-1:0] >> (COEF_FRAC_BITS - WB));
               nb_ff <= 3'd0;
               if (axis_ff == 2'd2) begin
                  axis_ff <= 2'd0;
                  if (outside_ff || rsrc < 0 || rsrc > rlim)
                     state_ff <= S_DONE;
                  else
                     state_ff <= S_READ;
               end else begin
                  axis_ff <= axis_ff + 2'd1;
               end
            end
            S_READ: begin
               // issue one read a cycle; fold the one returning now
               rd_nb_ff <= nb_ff;
               nb_ff    <= nb_ff + 3'd1;
               if (rd_pend_ff && rd_nb_ff == 3'd7) begin
                  rd_pend_ff <= 1'b0;
                  state_ff   <= S_BLEND;
               end else begin
                  rd_pend_ff <= 1'b1;
               end
               if (rd_pend_ff) begin
                  if (!rd_nb_ff[0]) xacc_ff <= AX'(vrd) * AX'(wxc);
                  else a_ff[rd_nb_ff[2:1]] <= AY'(xacc_ff + AX'(vrd) * AX'(wx));
               end
            end
            S_BLEND: begin
               b_ff[0] <= AY'(ylerp0 >>> WB);
               b_ff[1] <= AY'(ylerp1 >>> WB);
               state_ff <= S_ZBLEND;
            end
            S_ZBLEND: state_ff <= S_DONE;
            S_DONE: begin
               if (rsp_load) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // z blend register, loaded from b_ff in the cycle after b_ff is written
   always_ff @(posedge clock) begin
      z_ff <= AZ'(zlerp);
   end
endmodule
`default_nettype wire

/* src/vrt_checker.sv */
// Checker: port-level properties of the sampler, bound to the top level.
`default_nettype none
module vrt_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_inside,
   input wire logic [15:0] rsp_value
);
   // one item at a time: ready drops after an accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("second item taken while busy");
   // outside results carry zero
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_inside |-> rsp_value == 16'd0) else $error("outside nonzero");
   // result held under stall
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
      else $error("result dropped");
   // inside flag held under stall
   a_hold_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_inside)) else $error("flag changed");
endmodule

bind volume_rotate_trilinear vrt_checker u_chk (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_inside(rsp.inside_res), .rsp_value(rsp.out_value)
);
`default_nettype wire

/* sim/vrt_checker.sv */
// Checker: predicts rotated-volume samples from observed traffic and compares results.
`default_nettype none
module vrt_scoreboard
   import vrt_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   vrt_req_if                            req,
   vrt_rsp_if                            rsp,
   input  wire logic                     csr_wr_en,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_data,
   output int                            fail_count,
   output int                            pending,
   output int                            checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint ONE  = 64'sd65536;
   localparam int     SIDE = 32;

   typedef struct packed {
      logic signed [15:0] value;
      logic               in_vol;
   } sample_type;

   // shadow copy of the block's settings and voxel memory
   logic        [5:0]  side_reg [3];
   logic        [53:0] coef_row [3];
   logic signed [15:0] vox_mem [SIDE*SIDE*SIDE];
   sample_type         expected_q [$];

   function automatic longint eff_side(input logic [5:0] s);
      if (s < 2) return 2;
      if (s > SIDE) return SIDE;
      return longint'(s);
   endfunction

   function automatic longint vox(input longint x, input longint y, input longint z);
      return longint'(vox_mem[x + y*SIDE + z*SIDE*SIDE]);
   endfunction

   function automatic longint blend(input longint a, input longint b, input longint w);
      return a * (ONE - w) + b * w;
   endfunction

   // source-point mapping plus trilinear blend
   function automatic sample_type sample_point(input logic [4:0] x, input logic [4:0] y,
                                               input logic [4:0] z);
      longint  lim [3];
      longint  piv [3];
      longint  d [3];
      longint  base [3];
      longint  nxt [3];
      longint  w [3];
      longint  r, a0, a1, a2, a3, b0, b1, acc, res;
      sample_type s;
      s.in_vol = 1'b1;
      s.value  = '0;
      for (int ax = 0; ax < 3; ax++) begin
         lim[ax] = eff_side(side_reg[ax]);
         piv[ax] = lim[ax] / 2;
      end
      d[0] = longint'(x) - piv[0];
      d[1] = longint'(y) - piv[1];
      d[2] = longint'(z) - piv[2];
      for (int ax = 0; ax < 3; ax++) begin
         r = piv[ax] * ONE;
         for (int t = 0; t < 3; t++)
            r += longint'($signed(coef_row[ax][18*t +: 18])) * d[t];
         if (r < 0 || r > (lim[ax] - 1) * ONE) begin
            s.in_vol = 1'b0;
         end else begin
            base[ax] = r >>> 16;
            nxt[ax]  = (base[ax] + 1 < lim[ax]) ? base[ax] + 1 : lim[ax] - 1;
            w[ax]    = r & (ONE - 1);
         end
      end
      if (!s.in_vol) return s;
      a0 = blend(vox(base[0], base[1], base[2]), vox(nxt[0], base[1], base[2]), w[0]);
      a1 = blend(vox(base[0], nxt[1], base[2]), vox(nxt[0], nxt[1], base[2]), w[0]);
      a2 = blend(vox(base[0], base[1], nxt[2]), vox(nxt[0], base[1], nxt[2]), w[0]);
      a3 = blend(vox(base[0], nxt[1], nxt[2]), vox(nxt[0], nxt[1], nxt[2]), w[0]);
      b0 = blend(a0, a1, w[1]) >>> 16;
      b1 = blend(a2, a3, w[1]) >>> 16;
      acc = blend(b0, b1, w[2]);
      // z stage rounds toward zero
      res = (acc < 0) ? -((-acc) >>> 32) : (acc >>> 32);
      s.value = res[15:0];
      return s;
   endfunction

   assign pending = expected_q.size();

   always @(posedge clock) begin
      sample_type exp_s;
      if (reset) begin
         side_reg[0] <= 6'd32;
         side_reg[1] <= 6'd32;
         side_reg[2] <= 6'd32;
         coef_row[0] <= 54'd1 << 16;
         coef_row[1] <= 54'd1 << 34;
         coef_row[2] <= 54'd1 << 52;
         expected_q.delete();
         fail_count <= 0;
         checked    <= 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SIZE_X: side_reg[0] <= csr_data[5:0];
               CSR_SIZE_Y: side_reg[1] <= csr_data[5:0];
               CSR_SIZE_Z: side_reg[2] <= csr_data[5:0];
               CSR_COEF_X: coef_row[0] <= csr_data;
               CSR_COEF_Y: coef_row[1] <= csr_data;
               CSR_COEF_Z: coef_row[2] <= csr_data;
               default: ;
            endcase
         end
         // accepted request item
         if (req.valid && req.ready) begin
            if (req.req_type == REQ_STORE) begin
               if (req.coord_x < eff_side(side_reg[0]) && req.coord_y < eff_side(side_reg[1])
                   && req.coord_z < eff_side(side_reg[2]))
                  vox_mem[req.coord_x + req.coord_y*SIDE + req.coord_z*SIDE*SIDE] =
                     req.voxel_value;
            end else begin
               expected_q.push_back(sample_point(req.coord_x, req.coord_y, req.coord_z));
            end
         end
         // accepted result item
         if (rsp.valid && rsp.ready) begin
            if (expected_q.size() == 0) begin
               if (fail_count < 10)
                  $display("ERROR: result item with nothing expected: value %0d inside %0b",
                           rsp.out_value, rsp.inside_res);
               fail_count <= fail_count + 1;
            end else begin
               exp_s = expected_q.pop_front();
               checked <= checked + 1;
               if (rsp.out_value !== exp_s.value || rsp.inside_res !== exp_s.in_vol) begin
                  if (fail_count < 10)
                     $display("ERROR: sample mismatch: expected value %0d inside %0b, got %0d %0b",
                              exp_s.value, exp_s.in_vol, rsp.out_value, rsp.inside_res);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule
`default_nettype wire

/* sim/tb.sv */
// Testbench top: clock, reset, stimulus and verdict for the rotated-volume sampler.
`default_nettype none
module tb;
   import vrt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic                     clock;
   logic                     reset;
   logic                     csr_wr_en;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_data;
   int                       fail_count, pending, checked;
   int                       send_idle_pct, recv_idle_pct, hold_cycles;
   int                       items_sent, side [3];

   vrt_req_if req_ch ();
   vrt_rsp_if rsp_ch ();

   volume_rotate_trilinear DUT (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_data(csr_data)
   );

   vrt_scoreboard chk (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending), .checked(checked)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("timeout with %0d results outstanding", pending);
      $display("*** FAILED ***");
      $finish;
   end

   // receiver: random stalls, plus one long hold-off when requested
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   function automatic int eff_side(input int s);
      return (s < 2) ? 2 : (s > 32) ? 32 : s;
   endfunction

   function automatic logic [53:0] pack_row(input int c0, input int c1, input int c2);
      logic [17:0] t0, t1, t2;
      t0 = c0[17:0];
      t1 = c1[17:0];
      t2 = c2[17:0];
      return {t2, t1, t0};
   endfunction

   // random matrix term of magnitude up to about 1.14, with a fraction
   function automatic int rot_term();
      return int'($urandom_range(0, 150000)) - 75000;
   endfunction

   task automatic send_item(input logic kind, input int x, input int y, input int z,
                            input int v);
      if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.req_type    <= kind;
      req_ch.coord_x     <= x[4:0];
      req_ch.coord_y     <= y[4:0];
      req_ch.coord_z     <= z[4:0];
      req_ch.voxel_value <= v[15:0];
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   // program all registers while the block is idle
   task automatic write_regs(input int sx, input int sy, input int sz,
                             input logic [53:0] rx, input logic [53:0] ry,
                             input logic [53:0] rz);
      csr_index_type idx [6];
      logic [53:0]   val [6];
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      idx = '{CSR_SIZE_X, CSR_SIZE_Y, CSR_SIZE_Z, CSR_COEF_X, CSR_COEF_Y, CSR_COEF_Z};
      val = '{54'(sx), 54'(sy), 54'(sz), rx, ry, rz};
      for (int i = 0; i < 6; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= val[i];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      side[0] = eff_side(sx);
      side[1] = eff_side(sy);
      side[2] = eff_side(sz);
   endtask

   // write every voxel of the configured region so no read hits an unwritten entry
   task automatic fill_region();
      for (int z = 0; z < side[2]; z++)
         for (int y = 0; y < side[1]; y++)
            for (int x = 0; x < side[0]; x++)
               send_item(REQ_STORE, x, y, z, $urandom);
   endtask

   task automatic random_items(input int count);
      int x, y, z;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 80) begin
            x = $urandom_range(0, side[0] - 1);
            y = $urandom_range(0, side[1] - 1);
            z = $urandom_range(0, side[2] - 1);
         end else begin
            x = $urandom_range(0, 31);
            y = $urandom_range(0, 31);
            z = $urandom_range(0, 31);
         end
         send_item(($urandom_range(0, 99) < 55) ? REQ_COMPUTE : REQ_STORE, x, y, z, $urandom);
      end
   endtask

   initial begin
      int          sizes [7][3];
      logic [53:0] rows [3];
      csr_wr_en          <= 1'b0;
      csr_index          <= CSR_SIZE_X;
      csr_data           <= '0;
      req_ch.valid       <= 1'b0;
      req_ch.req_type    <= REQ_STORE;
      req_ch.coord_x     <= '0;
      req_ch.coord_y     <= '0;
      req_ch.coord_z     <= '0;
      req_ch.voxel_value <= '0;
      send_idle_pct = 32;
      recv_idle_pct = 48;
      hold_cycles   = 0;
      items_sent    = 0;
      reset <= 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // sizes per phase, out-of-range values included
      sizes = '{'{4, 4, 4}, '{1, 2, 0}, '{32, 2, 2}, '{2, 63, 3}, '{3, 2, 32},
                '{5, 6, 7}, '{8, 8, 8}};
      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: rows = '{pack_row(65536, 0, 0), pack_row(0, 65536, 0), pack_row(0, 0, 65536)};
            1: rows = '{pack_row(131071, -131072, 32768), pack_row(-131072, 131071, -1),
                        pack_row(1, -32768, 131071)};
            4: rows = '{54'({$urandom, $urandom}), 54'({$urandom, $urandom}),
                        54'({$urandom, $urandom})};
            default: rows = '{pack_row(rot_term(), rot_term(), rot_term()),
                              pack_row(rot_term(), rot_term(), rot_term()),
                              pack_row(rot_term(), rot_term(), rot_term())};
         endcase
         if (ph == 3) begin
            send_idle_pct = 48;
            recv_idle_pct = 32;
         end else if (ph == 5) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_regs(sizes[ph][0], sizes[ph][1], sizes[ph][2], rows[0], rows[1], rows[2]);
         fill_region();
         if (ph == 0) begin
            // extremes, edge hits and ignored stores under the identity matrix
            send_item(REQ_STORE, 0, 0, 0, -32768);
            send_item(REQ_STORE, 3, 3, 3, 32767);
            send_item(REQ_STORE, 3, 0, 0, 32767);
            send_item(REQ_STORE, 4, 0, 0, 1234);
            send_item(REQ_STORE, 31, 31, 31, -1);
            send_item(REQ_COMPUTE, 0, 0, 0, 0);
            send_item(REQ_COMPUTE, 3, 3, 3, 0);
            send_item(REQ_COMPUTE, 3, 0, 0, -1);
            send_item(REQ_COMPUTE, 2, 2, 2, 0);
            send_item(REQ_COMPUTE, 4, 0, 0, 0);
            send_item(REQ_COMPUTE, 31, 31, 31, 0);
            send_item(REQ_COMPUTE, 0, 3, 31, 0);
            // long receiver hold-off while items keep coming
            hold_cycles = 300;
         end
         random_items(70);
      end

      req_ch.valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("Sent %0d request items over 7 size/matrix settings; %0d samples checked.",
               items_sent, checked);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule
`default_nettype wire

/* sim.f */
src/vrt_pkg.sv
src/vrt_if.sv
src/vrt_ram.sv
src/volume_rotate_trilinear.sv
src/vrt_checker.sv
sim/vrt_checker.sv
sim/tb.sv
